// ===== src/tks_pkg.sv =====
// Shared types, character codes, token kinds and lookup functions of the token scanner.
package tks_pkg;

  // Result field widths.
  typedef logic [31:0] offset_t;
  typedef logic [15:0] length_t;

  // Keyword window: the first five identifier bytes.
  localparam int KW_COUNT   = 5;
  localparam int KW_MAX_LEN = 5;
  typedef logic [8*KW_MAX_LEN-1:0] kw_window_t;

  typedef enum logic [4:0] {
    KIND_END         = 5'd0,
    KIND_IDENT       = 5'd1,
    KIND_INT         = 5'd2,
    KIND_FLOAT       = 5'd3,
    KIND_STRING      = 5'd4,
    KIND_IF          = 5'd5,
    KIND_ELSE        = 5'd6,
    KIND_WHILE       = 5'd7,
    KIND_VAR         = 5'd8,
    KIND_CONST       = 5'd9,
    KIND_PLUS        = 5'd10,
    KIND_MINUS       = 5'd11,
    KIND_STAR        = 5'd12,
    KIND_SLASH       = 5'd13,
    KIND_ASSIGN      = 5'd14,
    KIND_EQUAL       = 5'd15,
    KIND_NOT         = 5'd16,
    KIND_NOT_EQUAL   = 5'd17,
    KIND_LESS        = 5'd18,
    KIND_LESS_EQ     = 5'd19,
    KIND_GREATER     = 5'd20,
    KIND_GREATER_EQ  = 5'd21,
    KIND_LBRACE      = 5'd22,
    KIND_RBRACE      = 5'd23,
    KIND_LPAREN      = 5'd24,
    KIND_RPAREN      = 5'd25,
    KIND_LSQUARE     = 5'd26,
    KIND_RSQUARE     = 5'd27,
    KIND_COMMA       = 5'd28,
    KIND_SEMI        = 5'd29,
    KIND_ERROR       = 5'd30
  } kind_e;

  // Scan modes, one-hot.
  typedef enum logic [11:0] {
    MODE_IDLE    = 12'b0000_0000_0001,
    MODE_IDENT   = 12'b0000_0000_0010,
    MODE_INT     = 12'b0000_0000_0100,
    MODE_FRAC    = 12'b0000_0000_1000,
    MODE_STRING  = 12'b0000_0001_0000,
    MODE_SLASH   = 12'b0000_0010_0000,
    MODE_COMMENT = 12'b0000_0100_0000,
    MODE_EQ      = 12'b0000_1000_0000,
    MODE_BANG    = 12'b0001_0000_0000,
    MODE_LT      = 12'b0010_0000_0000,
    MODE_GT      = 12'b0100_0000_0000,
    MODE_DONE    = 12'b1000_0000_0000
  } mode_e;

  typedef struct packed {
    kind_e   kind;
    offset_t start;
    length_t length;
    logic    last;
  } result_t;

  typedef struct packed {
    logic    valid;
    result_t res;
  } slot_t;

  // Result queue geometry.
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);
  typedef logic [FIFO_PTR_W-1:0] fifo_ptr_t;
  typedef logic [FIFO_CNT_W-1:0] fifo_cnt_t;

  // Character codes.
  localparam logic [7:0] CH_NUL     = 8'h00;
  localparam logic [7:0] CH_TAB     = 8'h09;
  localparam logic [7:0] CH_CR      = 8'h0d;
  localparam logic [7:0] CH_LF      = 8'h0a;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_BANG    = 8'h21;
  localparam logic [7:0] CH_QUOTE   = 8'h22;
  localparam logic [7:0] CH_LPAREN  = 8'h28;
  localparam logic [7:0] CH_RPAREN  = 8'h29;
  localparam logic [7:0] CH_STAR    = 8'h2a;
  localparam logic [7:0] CH_PLUS    = 8'h2b;
  localparam logic [7:0] CH_COMMA   = 8'h2c;
  localparam logic [7:0] CH_MINUS   = 8'h2d;
  localparam logic [7:0] CH_DOT     = 8'h2e;
  localparam logic [7:0] CH_SLASH   = 8'h2f;
  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_NINE    = 8'h39;
  localparam logic [7:0] CH_SEMI    = 8'h3b;
  localparam logic [7:0] CH_LT      = 8'h3c;
  localparam logic [7:0] CH_EQ      = 8'h3d;
  localparam logic [7:0] CH_GT      = 8'h3e;
  localparam logic [7:0] CH_UPPER_A = 8'h41;
  localparam logic [7:0] CH_UPPER_Z = 8'h5a;
  localparam logic [7:0] CH_LSQUARE = 8'h5b;
  localparam logic [7:0] CH_RSQUARE = 8'h5d;
  localparam logic [7:0] CH_UNDER   = 8'h5f;
  localparam logic [7:0] CH_LOWER_A = 8'h61;
  localparam logic [7:0] CH_LOWER_Z = 8'h7a;
  localparam logic [7:0] CH_LBRACE  = 8'h7b;
  localparam logic [7:0] CH_RBRACE  = 8'h7d;

  // Keywords, right-aligned in the window with zero fill above.
  localparam kw_window_t KW_TEXT [KW_COUNT] = '{
    40'h00_0000_6966,   // if
    40'h00_656c_7365,   // else
    40'h77_6869_6c65,   // while
    40'h00_0076_6172,   // var
    40'h63_6f6e_7374    // const
  };
  localparam logic [2:0] KW_LEN [KW_COUNT] = '{3'd2, 3'd4, 3'd5, 3'd3, 3'd5};
  localparam kind_e KW_KIND [KW_COUNT] = '{
    KIND_IF, KIND_ELSE, KIND_WHILE, KIND_VAR, KIND_CONST
  };

  function automatic logic is_space(logic [7:0] c);
    return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
  endfunction

  function automatic logic is_digit(logic [7:0] c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

  function automatic logic is_alpha(logic [7:0] c);
    return ((c >= CH_LOWER_A) && (c <= CH_LOWER_Z)) ||
           ((c >= CH_UPPER_A) && (c <= CH_UPPER_Z));
  endfunction

  // len is the identifier length when it is at most five, else zero.
  function automatic kind_e kw_lookup(kw_window_t win, logic [2:0] len);
    kind_e kind;
    kind = KIND_IDENT;
    for (int k = 0; k < KW_COUNT; k++) begin
      if ((len == KW_LEN[k]) && (win == KW_TEXT[k])) begin
        kind = KW_KIND[k];
      end
    end
    return kind;
  endfunction

  // Kind of a byte that forms a complete token on its own.
  function automatic kind_e op_kind(logic [7:0] c);
    kind_e kind;
    case (c)
      CH_PLUS:    kind = KIND_PLUS;
      CH_MINUS:   kind = KIND_MINUS;
      CH_STAR:    kind = KIND_STAR;
      CH_LBRACE:  kind = KIND_LBRACE;
      CH_RBRACE:  kind = KIND_RBRACE;
      CH_LPAREN:  kind = KIND_LPAREN;
      CH_RPAREN:  kind = KIND_RPAREN;
      CH_LSQUARE: kind = KIND_LSQUARE;
      CH_RSQUARE: kind = KIND_RSQUARE;
      CH_COMMA:   kind = KIND_COMMA;
      CH_SEMI:    kind = KIND_SEMI;
      default:    kind = KIND_ERROR;
    endcase
    return kind;
  endfunction

endpackage

// ===== src/tks_in_if.sv =====
// Byte input channel of the token scanner.
interface tks_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic       end_mark;

  modport source (output valid, text_byte, end_mark, input ready);
  modport sink   (input valid, text_byte, end_mark, output ready);
endinterface

// ===== src/tks_out_if.sv =====
// Token output channel of the token scanner.
interface tks_out_if;
  logic        valid;
  logic        ready;
  logic [4:0]  token_kind;
  logic [31:0] start_offset;
  logic [15:0] text_length;
  logic        last_of_run;

  modport source (output valid, token_kind, start_offset, text_length, last_of_run,
                  input ready);
  modport sink   (input valid, token_kind, start_offset, text_length, last_of_run,
                  output ready);
endinterface

// ===== src/tks_scan_core.sv =====
// Scan state and per-byte next-state and token logic of the token scanner.
module tks_scan_core #(
  parameter int OFFSET_BITS = 32,
  parameter int LENGTH_BITS = 16
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            fire_i,
  input  logic [7:0]      text_byte_i,
  input  logic            end_mark_i,
  output tks_pkg::slot_t  slot0_o,
  output tks_pkg::slot_t  slot1_o
);

  typedef logic [OFFSET_BITS-1:0] pos_t;
  typedef logic [LENGTH_BITS-1:0] len_t;

  tks_pkg::mode_e      mode_q, mode_d;
  pos_t                pos_q, pos_d;
  pos_t                start_q, start_d;
  len_t                len_q, len_d;
  tks_pkg::kw_window_t win_q, win_d;

  logic [7:0] c;
  assign c = text_byte_i;

  // Token held open by the current mode.
  logic             flush_v;
  tks_pkg::result_t flush_res;
  logic [2:0]       short_len;

  assign short_len = (len_q <= len_t'(tks_pkg::KW_MAX_LEN)) ? len_q[2:0] : 3'd0;

  always_comb begin
    flush_v          = 1'b1;
    flush_res.kind   = tks_pkg::KIND_IDENT;
    flush_res.start  = tks_pkg::offset_t'(start_q);
    flush_res.length = tks_pkg::length_t'(1);
    flush_res.last   = 1'b0;
    case (mode_q)
      tks_pkg::MODE_IDENT: begin
        flush_res.kind   = tks_pkg::kw_lookup(win_q, short_len);
        flush_res.length = tks_pkg::length_t'(len_q);
      end
      tks_pkg::MODE_INT: begin
        flush_res.kind   = tks_pkg::KIND_INT;
        flush_res.length = tks_pkg::length_t'(len_q);
      end
      tks_pkg::MODE_FRAC: begin
        flush_res.kind   = tks_pkg::KIND_FLOAT;
        flush_res.length = tks_pkg::length_t'(len_q);
      end
      tks_pkg::MODE_STRING: begin
        flush_res.kind   = tks_pkg::KIND_STRING;
        flush_res.length = tks_pkg::length_t'(len_q);
      end
      tks_pkg::MODE_SLASH: flush_res.kind = tks_pkg::KIND_SLASH;
      tks_pkg::MODE_EQ:    flush_res.kind = tks_pkg::KIND_ASSIGN;
      tks_pkg::MODE_BANG:  flush_res.kind = tks_pkg::KIND_NOT;
      tks_pkg::MODE_LT:    flush_res.kind = tks_pkg::KIND_LESS;
      tks_pkg::MODE_GT:    flush_res.kind = tks_pkg::KIND_GREATER;
      default:             flush_v = 1'b0;
    endcase
  end

  // Two-character operator when '=' follows.
  tks_pkg::result_t pair_res;

  always_comb begin
    pair_res.start  = tks_pkg::offset_t'(start_q);
    pair_res.length = tks_pkg::length_t'(2);
    pair_res.last   = 1'b1;
    case (mode_q)
      tks_pkg::MODE_EQ:   pair_res.kind = tks_pkg::KIND_EQUAL;
      tks_pkg::MODE_BANG: pair_res.kind = tks_pkg::KIND_NOT_EQUAL;
      tks_pkg::MODE_LT:   pair_res.kind = tks_pkg::KIND_LESS_EQ;
      default:            pair_res.kind = tks_pkg::KIND_GREATER_EQ;
    endcase
  end

  // Byte that arrives between tokens.
  logic                idle_v;
  tks_pkg::result_t    idle_res;
  tks_pkg::mode_e      idle_mode;
  logic                idle_begin;
  pos_t                idle_start;
  len_t                idle_len;
  tks_pkg::kw_window_t idle_win;

  always_comb begin
    idle_v          = 1'b0;
    idle_res.kind   = tks_pkg::op_kind(c);
    idle_res.start  = tks_pkg::offset_t'(pos_q);
    idle_res.length = tks_pkg::length_t'(1);
    idle_res.last   = 1'b1;
    idle_mode       = tks_pkg::MODE_IDLE;
    idle_begin      = 1'b0;
    idle_start      = pos_q;
    idle_len        = len_t'(1);
    idle_win        = '0;
    if (tks_pkg::is_space(c)) begin
      idle_mode = tks_pkg::MODE_IDLE;
    end else if (tks_pkg::is_alpha(c)) begin
      idle_begin = 1'b1;
      idle_mode  = tks_pkg::MODE_IDENT;
      idle_win   = tks_pkg::kw_window_t'(c);
    end else if (tks_pkg::is_digit(c)) begin
      idle_begin = 1'b1;
      idle_mode  = tks_pkg::MODE_INT;
    end else begin
      case (c)
        tks_pkg::CH_NUL: begin
          idle_v          = 1'b1;
          idle_res.kind   = tks_pkg::KIND_END;
          idle_res.length = '0;
          idle_mode       = tks_pkg::MODE_DONE;
        end
        tks_pkg::CH_QUOTE: begin
          idle_begin = 1'b1;
          idle_mode  = tks_pkg::MODE_STRING;
          idle_start = pos_q + pos_t'(1);
          idle_len   = '0;
        end
        tks_pkg::CH_SLASH: begin
          idle_begin = 1'b1;
          idle_mode  = tks_pkg::MODE_SLASH;
        end
        tks_pkg::CH_EQ: begin
          idle_begin = 1'b1;
          idle_mode  = tks_pkg::MODE_EQ;
        end
        tks_pkg::CH_BANG: begin
          idle_begin = 1'b1;
          idle_mode  = tks_pkg::MODE_BANG;
        end
        tks_pkg::CH_LT: begin
          idle_begin = 1'b1;
          idle_mode  = tks_pkg::MODE_LT;
        end
        tks_pkg::CH_GT: begin
          idle_begin = 1'b1;
          idle_mode  = tks_pkg::MODE_GT;
        end
        default: idle_v = 1'b1;
      endcase
    end
  end

  // Next state and up to two results.
  logic             a_v, b_v;
  tks_pkg::result_t a_res, b_res;
  logic             do_flush, do_idle, do_grow, grow_ident;

  always_comb begin
    mode_d     = mode_q;
    pos_d      = pos_q;
    start_d    = start_q;
    len_d      = len_q;
    win_d      = win_q;
    a_v        = 1'b0;
    a_res      = flush_res;
    b_v        = 1'b0;
    b_res      = idle_res;
    do_flush   = 1'b0;
    do_idle    = 1'b0;
    do_grow    = 1'b0;
    grow_ident = 1'b0;

    if (fire_i && end_mark_i) begin
      a_v = flush_v;
      if (mode_q != tks_pkg::MODE_DONE) begin
        b_v            = 1'b1;
        b_res.kind     = tks_pkg::KIND_END;
        b_res.start    = tks_pkg::offset_t'(pos_q);
        b_res.length   = '0;
      end
      mode_d  = tks_pkg::MODE_IDLE;
      pos_d   = '0;
      start_d = '0;
      len_d   = '0;
      win_d   = '0;
    end else if (fire_i) begin
      pos_d = pos_q + pos_t'(1);
      case (mode_q)
        tks_pkg::MODE_IDENT: begin
          if (tks_pkg::is_alpha(c) || tks_pkg::is_digit(c) || (c == tks_pkg::CH_UNDER)) begin
            do_grow    = 1'b1;
            grow_ident = 1'b1;
          end else begin
            do_flush = 1'b1;
            do_idle  = 1'b1;
          end
        end
        tks_pkg::MODE_INT: begin
          if (tks_pkg::is_digit(c)) begin
            do_grow = 1'b1;
          end else if (c == tks_pkg::CH_DOT) begin
            do_grow = 1'b1;
            mode_d  = tks_pkg::MODE_FRAC;
          end else begin
            do_flush = 1'b1;
            do_idle  = 1'b1;
          end
        end
        tks_pkg::MODE_FRAC: begin
          if (tks_pkg::is_digit(c)) begin
            do_grow = 1'b1;
          end else begin
            do_flush = 1'b1;
            do_idle  = 1'b1;
          end
        end
        tks_pkg::MODE_STRING: begin
          if (c == tks_pkg::CH_QUOTE) begin
            do_flush = 1'b1;
          end else begin
            do_grow = 1'b1;
          end
        end
        tks_pkg::MODE_SLASH: begin
          if (c == tks_pkg::CH_SLASH) begin
            mode_d = tks_pkg::MODE_COMMENT;
          end else begin
            do_flush = 1'b1;
            do_idle  = 1'b1;
          end
        end
        tks_pkg::MODE_COMMENT: begin
          if (c == tks_pkg::CH_LF) begin
            mode_d = tks_pkg::MODE_IDLE;
          end
        end
        tks_pkg::MODE_EQ, tks_pkg::MODE_BANG, tks_pkg::MODE_LT, tks_pkg::MODE_GT: begin
          if (c == tks_pkg::CH_EQ) begin
            a_v    = 1'b1;
            a_res  = pair_res;
            mode_d = tks_pkg::MODE_IDLE;
          end else begin
            do_flush = 1'b1;
            do_idle  = 1'b1;
          end
        end
        tks_pkg::MODE_DONE: mode_d = tks_pkg::MODE_DONE;
        default:            do_idle = 1'b1;
      endcase

      if (do_grow) begin
        if (grow_ident && (len_q < len_t'(tks_pkg::KW_MAX_LEN))) begin
          win_d = {win_q[8*tks_pkg::KW_MAX_LEN-9:0], c};
        end
        if (len_q != '1) begin
          len_d = len_q + len_t'(1);
        end
      end

      if (do_flush) begin
        a_v    = 1'b1;
        mode_d = tks_pkg::MODE_IDLE;
      end

      if (do_idle) begin
        b_v    = idle_v;
        mode_d = idle_mode;
        if (idle_begin) begin
          start_d = idle_start;
          len_d   = idle_len;
          win_d   = idle_win;
        end
      end
    end
  end

  // Pack results in order; mark the final one of this byte.
  always_comb begin
    slot0_o.valid    = a_v | b_v;
    slot0_o.res      = a_v ? a_res : b_res;
    slot0_o.res.last = a_v ? !b_v : 1'b1;
    slot1_o.valid    = a_v & b_v;
    slot1_o.res      = b_res;
    slot1_o.res.last = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= tks_pkg::MODE_IDLE;
      pos_q   <= '0;
      start_q <= '0;
      len_q   <= '0;
      win_q   <= '0;
    end else begin
      mode_q  <= mode_d;
      pos_q   <= pos_d;
      start_q <= start_d;
      len_q   <= len_d;
      win_q   <= win_d;
    end
  end

endmodule

// ===== src/tks_result_fifo.sv =====
// Small result queue: up to two writes and one read per cycle.
module tks_result_fifo (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  tks_pkg::slot_t   slot0_i,
  input  tks_pkg::slot_t   slot1_i,
  input  logic             pop_i,
  output tks_pkg::result_t head_o,
  output logic             valid_o,
  output logic             room_o
);

  tks_pkg::result_t   entry_q [tks_pkg::FIFO_DEPTH];
  tks_pkg::fifo_ptr_t wr_ptr_q, rd_ptr_q;
  tks_pkg::fifo_cnt_t count_q;
  tks_pkg::fifo_cnt_t push_n;
  logic               pop;

  assign push_n  = tks_pkg::fifo_cnt_t'(slot0_i.valid) + tks_pkg::fifo_cnt_t'(slot1_i.valid);
  assign valid_o = (count_q != '0);
  assign pop     = pop_i & valid_o;
  assign head_o  = entry_q[rd_ptr_q];
  // Room for a full two-result write.
  assign room_o  = (count_q <= tks_pkg::fifo_cnt_t'(tks_pkg::FIFO_DEPTH - 2));

  always_ff @(posedge clk_i) begin
    if (slot0_i.valid) begin
      entry_q[wr_ptr_q] <= slot0_i.res;
    end
    if (slot1_i.valid) begin
      entry_q[wr_ptr_q + tks_pkg::fifo_ptr_t'(1)] <= slot1_i.res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_q + tks_pkg::fifo_ptr_t'(push_n);
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + tks_pkg::fifo_ptr_t'(1);
      end
      count_q <= count_q + push_n - tks_pkg::fifo_cnt_t'(pop);
    end
  end

endmodule

// ===== src/token_scanner.sv =====
// Top level of the token scanner: input register, scan core and result queue.
//
// Usage: source text enters on in_i one byte per beat (text_byte), or an
// end_mark beat that closes the stream. Tokens leave on out_o as kind,
// start offset and length; last_of_run flags the final token caused by
// one input beat. A byte causes zero, one or two tokens.
// Path: an accepted byte waits in the input register until the queue has
// room, is then scanned, and its tokens are registered in the queue for out_o.
// Throughput: one byte per cycle when the queue has room; a scan is a single
// pass of logic between the input register and a four-entry result queue.
// Bytes that yield two tokens need two output beats, so a long run of them
// limits input to the output rate.
// Stall: when out_o is not ready the queue fills; once it lacks room for
// two tokens the input register holds its byte and in_i.ready drops.
// Reset: scanner idle between tokens at offset 0, queue empty. An end_mark
// beat also returns the scan state to offset 0 for the next stream.
module token_scanner #(
  parameter int OFFSET_BITS = 32,
  parameter int LENGTH_BITS = 16
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  tks_in_if.sink       in_i,
  tks_out_if.source    out_o
);

  // Input register: hold one byte beat until the core can take it.
  logic       in_valid_q;
  logic [7:0] in_byte_q;
  logic       in_end_q;
  logic       advance;
  logic       room;

  assign advance    = in_valid_q & room;
  assign in_i.ready = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      in_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.ready && in_i.valid) begin
      in_byte_q <= in_i.text_byte;
      in_end_q  <= in_i.end_mark;
    end
  end

  // Scan one byte per advance; results land in the queue at the same edge.
  tks_pkg::slot_t slot0, slot1;

  tks_scan_core #(
    .OFFSET_BITS (OFFSET_BITS),
    .LENGTH_BITS (LENGTH_BITS)
  ) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .fire_i      (advance),
    .text_byte_i (in_byte_q),
    .end_mark_i  (in_end_q),
    .slot0_o     (slot0),
    .slot1_o     (slot1)
  );

  // Result queue decouples the scan from output stalls.
  tks_pkg::result_t head;
  logic             head_valid;

  tks_result_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .slot0_i (slot0),
    .slot1_i (slot1),
    .pop_i   (out_o.ready),
    .head_o  (head),
    .valid_o (head_valid),
    .room_o  (room)
  );

  assign out_o.valid        = head_valid;
  assign out_o.token_kind   = head.kind;
  assign out_o.start_offset = head.start;
  assign out_o.text_length  = head.length;
  assign out_o.last_of_run  = head.last;

endmodule

// ===== test/token_scanner_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench of token_scanner: byte streams in, predicted tokens checked out.
module token_scanner_tb;

  // Run sizing: random beats, long-word tail length and the cycle ceiling.
  localparam int              RANDOM_BEATS = 540;
  localparam int              LONG_TAIL    = 40;
  localparam int unsigned     CYCLE_LIMIT  = 1_000_000;
  localparam tks_pkg::length_t LEN_SAT     = '1;

  // Keywords, right-aligned with zero fill as the first five bytes of a word.
  localparam logic [39:0] KW_WORD [5] = '{
    40'h00_0000_6966,   // if
    40'h00_656c_7365,   // else
    40'h77_6869_6c65,   // while
    40'h00_0076_6172,   // var
    40'h63_6f6e_7374    // const
  };
  localparam int             KW_SIZE [5] = '{2, 4, 5, 3, 5};
  localparam tks_pkg::kind_e KW_TOKEN [5] = '{
    tks_pkg::KIND_IF, tks_pkg::KIND_ELSE, tks_pkg::KIND_WHILE, tks_pkg::KIND_VAR,
    tks_pkg::KIND_CONST
  };

  typedef struct {
    tks_pkg::kind_e   kind;
    tks_pkg::offset_t start;
    tks_pkg::length_t length;
    logic             last;
  } token_t;

  logic clk_i;
  logic rst_ni;

  tks_in_if  in_if ();
  tks_out_if out_if ();

  token_scanner u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // Character pools for random text.
  string LETTERS   = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ";
  string DIGITS    = "0123456789";
  string WORD_TAIL = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ0123456789_";
  string OPS       = "+-*/=!<>{}()[],;";
  string KEYWORDS [5] = '{"if", "else", "while", "var", "const"};

  int          beats_sent    = 0;
  int          bad_tokens    = 0;
  int          tokens_seen   = 0;
  int          hold_request  = 0;
  bit          gaps_on       = 1'b1;
  bit          out_stalls_on = 1'b1;
  int unsigned cycle_count   = 0;

  // Shadow scan state: mode, next byte offset, open token and keyword window.
  tks_pkg::mode_e   lex_mode;
  tks_pkg::offset_t lex_pos;
  tks_pkg::offset_t lex_start;
  tks_pkg::length_t lex_len;
  logic [39:0]      lex_word;

  token_t beat_tokens[$];   // tokens of the beat being scanned
  token_t tokens_due[$];    // tokens predicted but not yet seen on out_if

  // ---------------------------------------------------------------------------
  // Token predictor
  // ---------------------------------------------------------------------------

  function automatic void clear_scan();
    lex_mode  = tks_pkg::MODE_IDLE;
    lex_pos   = '0;
    lex_start = '0;
    lex_len   = '0;
    lex_word  = '0;
  endfunction

  function automatic void add_token(tks_pkg::kind_e kind, tks_pkg::offset_t start,
                                    tks_pkg::length_t length);
    token_t t;
    t.kind   = kind;
    t.start  = start;
    t.length = length;
    t.last   = 1'b0;
    beat_tokens.push_back(t);
  endfunction

  function automatic bit blank_char(logic [7:0] c);
    return c inside {[8'h09:8'h0d], tks_pkg::CH_SPACE};
  endfunction

  function automatic bit digit_char(logic [7:0] c);
    return c inside {[tks_pkg::CH_ZERO:tks_pkg::CH_NINE]};
  endfunction

  function automatic bit letter_char(logic [7:0] c);
    return c inside {[tks_pkg::CH_LOWER_A:tks_pkg::CH_LOWER_Z],
                     [tks_pkg::CH_UPPER_A:tks_pkg::CH_UPPER_Z]};
  endfunction

  // A saturated word has length far above five, so it never matches a keyword.
  function automatic tks_pkg::kind_e word_kind();
    tks_pkg::kind_e kind;
    kind = tks_pkg::KIND_IDENT;
    for (int k = 0; k < 5; k++) begin
      if ((lex_len == tks_pkg::length_t'(KW_SIZE[k])) && (lex_word == KW_WORD[k])) begin
        kind = KW_TOKEN[k];
      end
    end
    return kind;
  endfunction

  // Extend the open token; only the first five word bytes enter the window.
  function automatic void extend_token(bit word, logic [7:0] c);
    if (word && (lex_len < 16'd5)) begin
      lex_word = {lex_word[31:0], c};
    end
    if (lex_len != LEN_SAT) begin
      lex_len = lex_len + 16'd1;
    end
  endfunction

  // Close whatever token the mode holds open.
  function automatic void close_token();
    case (lex_mode)
      tks_pkg::MODE_IDENT:  add_token(word_kind(), lex_start, lex_len);
      tks_pkg::MODE_INT:    add_token(tks_pkg::KIND_INT, lex_start, lex_len);
      tks_pkg::MODE_FRAC:   add_token(tks_pkg::KIND_FLOAT, lex_start, lex_len);
      tks_pkg::MODE_STRING: add_token(tks_pkg::KIND_STRING, lex_start, lex_len);
      tks_pkg::MODE_SLASH:  add_token(tks_pkg::KIND_SLASH, lex_start, 16'd1);
      tks_pkg::MODE_EQ:     add_token(tks_pkg::KIND_ASSIGN, lex_start, 16'd1);
      tks_pkg::MODE_BANG:   add_token(tks_pkg::KIND_NOT, lex_start, 16'd1);
      tks_pkg::MODE_LT:     add_token(tks_pkg::KIND_LESS, lex_start, 16'd1);
      tks_pkg::MODE_GT:     add_token(tks_pkg::KIND_GREATER, lex_start, 16'd1);
      default: ;
    endcase
    if (lex_mode != tks_pkg::MODE_DONE) begin
      lex_mode = tks_pkg::MODE_IDLE;
    end
  endfunction

  function automatic void open_token(tks_pkg::mode_e mode, tks_pkg::offset_t start,
                                     tks_pkg::length_t length);
    lex_mode  = mode;
    lex_start = start;
    lex_len   = length;
    lex_word  = '0;
  endfunction

  // Scan a byte that arrives between tokens.
  function automatic void start_token(logic [7:0] c, tks_pkg::offset_t pos);
    tks_pkg::kind_e kind;
    kind = tks_pkg::KIND_ERROR;
    if (blank_char(c)) begin
      return;
    end
    if (letter_char(c)) begin
      open_token(tks_pkg::MODE_IDENT, pos, 16'd1);
      lex_word = {32'd0, c};
      return;
    end
    if (digit_char(c)) begin
      open_token(tks_pkg::MODE_INT, pos, 16'd1);
      return;
    end
    case (c)
      tks_pkg::CH_NUL: begin
        add_token(tks_pkg::KIND_END, pos, 16'd0);
        lex_mode = tks_pkg::MODE_DONE;
        return;
      end
      tks_pkg::CH_QUOTE: begin
        open_token(tks_pkg::MODE_STRING, pos + 32'd1, 16'd0);
        return;
      end
      tks_pkg::CH_SLASH: begin
        open_token(tks_pkg::MODE_SLASH, pos, 16'd1);
        return;
      end
      tks_pkg::CH_EQ: begin
        open_token(tks_pkg::MODE_EQ, pos, 16'd1);
        return;
      end
      tks_pkg::CH_BANG: begin
        open_token(tks_pkg::MODE_BANG, pos, 16'd1);
        return;
      end
      tks_pkg::CH_LT: begin
        open_token(tks_pkg::MODE_LT, pos, 16'd1);
        return;
      end
      tks_pkg::CH_GT: begin
        open_token(tks_pkg::MODE_GT, pos, 16'd1);
        return;
      end
      tks_pkg::CH_PLUS:    kind = tks_pkg::KIND_PLUS;
      tks_pkg::CH_MINUS:   kind = tks_pkg::KIND_MINUS;
      tks_pkg::CH_STAR:    kind = tks_pkg::KIND_STAR;
      tks_pkg::CH_LBRACE:  kind = tks_pkg::KIND_LBRACE;
      tks_pkg::CH_RBRACE:  kind = tks_pkg::KIND_RBRACE;
      tks_pkg::CH_LPAREN:  kind = tks_pkg::KIND_LPAREN;
      tks_pkg::CH_RPAREN:  kind = tks_pkg::KIND_RPAREN;
      tks_pkg::CH_LSQUARE: kind = tks_pkg::KIND_LSQUARE;
      tks_pkg::CH_RSQUARE: kind = tks_pkg::KIND_RSQUARE;
      tks_pkg::CH_COMMA:   kind = tks_pkg::KIND_COMMA;
      tks_pkg::CH_SEMI:    kind = tks_pkg::KIND_SEMI;
      default: ;
    endcase
    add_token(kind, pos, 16'd1);
  endfunction

  // Resolve an open = ! < > against the byte after it.
  function automatic void finish_operator(logic [7:0] c, tks_pkg::offset_t pos,
                                          tks_pkg::kind_e two, tks_pkg::kind_e one);
    if (c == tks_pkg::CH_EQ) begin
      add_token(two, lex_start, 16'd2);
      lex_mode = tks_pkg::MODE_IDLE;
    end else begin
      add_token(one, lex_start, 16'd1);
      lex_mode = tks_pkg::MODE_IDLE;
      start_token(c, pos);
    end
  endfunction

  // Scan one accepted beat and queue the tokens it yields.
  function automatic void lex_beat(logic [7:0] c, logic end_mark);
    tks_pkg::offset_t pos;
    bit               was_done;
    pos = lex_pos;
    beat_tokens.delete();
    if (end_mark) begin
      was_done = (lex_mode == tks_pkg::MODE_DONE);
      close_token();
      if (!was_done) begin
        add_token(tks_pkg::KIND_END, pos, 16'd0);
      end
      clear_scan();
    end else begin
      case (lex_mode)
        tks_pkg::MODE_IDENT: begin
          if (letter_char(c) || digit_char(c) || (c == tks_pkg::CH_UNDER)) begin
            extend_token(1'b1, c);
          end else begin
            close_token();
            start_token(c, pos);
          end
        end
        tks_pkg::MODE_INT: begin
          if (digit_char(c)) begin
            extend_token(1'b0, c);
          end else if (c == tks_pkg::CH_DOT) begin
            extend_token(1'b0, c);
            lex_mode = tks_pkg::MODE_FRAC;
          end else begin
            close_token();
            start_token(c, pos);
          end
        end
        tks_pkg::MODE_FRAC: begin
          if (digit_char(c)) begin
            extend_token(1'b0, c);
          end else begin
            close_token();
            start_token(c, pos);
          end
        end
        tks_pkg::MODE_STRING: begin
          if (c == tks_pkg::CH_QUOTE) begin
            close_token();
          end else begin
            extend_token(1'b0, c);
          end
        end
        tks_pkg::MODE_SLASH: begin
          if (c == tks_pkg::CH_SLASH) begin
            lex_mode = tks_pkg::MODE_COMMENT;
          end else begin
            close_token();
            start_token(c, pos);
          end
        end
        tks_pkg::MODE_COMMENT: begin
          if (c == tks_pkg::CH_LF) begin
            lex_mode = tks_pkg::MODE_IDLE;
          end
        end
        tks_pkg::MODE_EQ:
          finish_operator(c, pos, tks_pkg::KIND_EQUAL, tks_pkg::KIND_ASSIGN);
        tks_pkg::MODE_BANG:
          finish_operator(c, pos, tks_pkg::KIND_NOT_EQUAL, tks_pkg::KIND_NOT);
        tks_pkg::MODE_LT:
          finish_operator(c, pos, tks_pkg::KIND_LESS_EQ, tks_pkg::KIND_LESS);
        tks_pkg::MODE_GT:
          finish_operator(c, pos, tks_pkg::KIND_GREATER_EQ, tks_pkg::KIND_GREATER);
        tks_pkg::MODE_DONE: ;
        default:   start_token(c, pos);
      endcase
      lex_pos = pos + 32'd1;
    end
    if (beat_tokens.size() > 0) begin
      beat_tokens[beat_tokens.size() - 1].last = 1'b1;
    end
    foreach (beat_tokens[i]) begin
      tokens_due.push_back(beat_tokens[i]);
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Checking: predict on input beats, compare on output beats, same edge
  // ---------------------------------------------------------------------------

  function automatic void log_error(string msg);
    bad_tokens++;
    if (bad_tokens <= 10) begin
      $display("%s", msg);
    end
  endfunction

  // Predict before comparing so a beat's tokens are queued first.
  always @(posedge clk_i) begin : check_tokens
    token_t want;
    if (rst_ni) begin
      if (in_if.valid && in_if.ready) begin
        lex_beat(in_if.text_byte, in_if.end_mark);
      end
      if (out_if.valid && out_if.ready) begin
        tokens_seen++;
        if (tokens_due.size() == 0) begin
          log_error($sformatf("token %0d unexpected: kind %0d start %0d len %0d last %0d",
                              tokens_seen, out_if.token_kind, out_if.start_offset,
                              out_if.text_length, out_if.last_of_run));
        end else begin
          want = tokens_due.pop_front();
          if ((out_if.token_kind !== want.kind) || (out_if.start_offset !== want.start) ||
              (out_if.text_length !== want.length) || (out_if.last_of_run !== want.last)) begin
            log_error($sformatf({"token %0d: expected kind %0d start %0d len %0d last %0d,",
                                 " got kind %0d start %0d len %0d last %0d"},
                                tokens_seen, want.kind, want.start, want.length, want.last,
                                out_if.token_kind, out_if.start_offset, out_if.text_length,
                                out_if.last_of_run));
          end
        end
      end
    end
  end

  // Abort a hung run.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Pacing
  // ---------------------------------------------------------------------------

  // Idle length: mostly short, now and then long.
  function automatic int gap_len();
    int pick;
    pick = $urandom_range(99);
    if (pick < 75) begin
      return $urandom_range(1, 3);
    end else if (pick < 95) begin
      return $urandom_range(4, 10);
    end
    return $urandom_range(20, 60);
  endfunction

  // Drive out_if.ready; a hold request from a test overrides random stalls.
  initial begin : out_pacing
    int stall_left;
    stall_left = 0;
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_request > 0) begin
        stall_left   = hold_request;
        hold_request = 0;
      end else if ((stall_left == 0) && out_stalls_on && ($urandom_range(99) < 20)) begin
        stall_left = gap_len();
      end
      out_if.ready <= (stall_left == 0);
      if (stall_left > 0) begin
        stall_left--;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  // Offer one beat, idling first at random; return at the accepting edge.
  task automatic send_beat(logic [7:0] c, logic end_mark);
    int gap;
    gap = 0;
    if (gaps_on && ($urandom_range(99) < 30)) begin
      gap = gap_len();
    end
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid     <= 1'b1;
    in_if.text_byte <= c;
    in_if.end_mark  <= end_mark;
    do @(posedge clk_i); while (in_if.ready !== 1'b1);
    beats_sent++;
  endtask

  task automatic send_text(string s);
    for (int i = 0; i < s.len(); i++) begin
      send_beat(s[i], 1'b0);
    end
  endtask

  // The byte lane carries noise on an end_mark beat.
  task automatic send_end();
    send_beat(8'($urandom), 1'b1);
  endtask

  function automatic logic [7:0] pick_char(string pool);
    return pool[$urandom_range(pool.len() - 1)];
  endfunction

  function automatic logic [7:0] blank_byte();
    if ($urandom_range(1) == 0) begin
      return tks_pkg::CH_SPACE;
    end
    return 8'(8'h09 + $urandom_range(4));
  endfunction

  // Drop valid, wait until every predicted token has left, then let the
  // pipeline settle. Sample at the falling edge so the last beat is predicted.
  task automatic wait_for_drain();
    in_if.valid <= 1'b0;
    do @(negedge clk_i); while (tokens_due.size() != 0);
    repeat (4) @(posedge clk_i);
  endtask

  // One random fragment of source text, well formed most of the time.
  task automatic send_random_piece();
    int         pick;
    logic [7:0] c;
    pick = $urandom_range(99);
    if (pick < 25) begin
      if ($urandom_range(3) == 0) begin
        send_text(KEYWORDS[$urandom_range(4)]);
        if ($urandom_range(2) == 0) begin
          send_beat(pick_char(WORD_TAIL), 1'b0);
        end
      end else begin
        send_beat(pick_char(LETTERS), 1'b0);
        repeat ($urandom_range(7)) send_beat(pick_char(WORD_TAIL), 1'b0);
      end
    end else if (pick < 40) begin
      repeat ($urandom_range(1, 4)) send_beat(pick_char(DIGITS), 1'b0);
      if ($urandom_range(1) == 0) begin
        send_beat(tks_pkg::CH_DOT, 1'b0);
        repeat ($urandom_range(3)) send_beat(pick_char(DIGITS), 1'b0);
        if ($urandom_range(5) == 0) begin
          send_beat(tks_pkg::CH_DOT, 1'b0);
        end
      end
    end else if (pick < 50) begin
      // Any byte but a quote is content, NUL and high bytes included.
      send_beat(tks_pkg::CH_QUOTE, 1'b0);
      repeat ($urandom_range(6)) begin
        do c = 8'($urandom_range(255)); while (c == tks_pkg::CH_QUOTE);
        send_beat(c, 1'b0);
      end
      if ($urandom_range(9) != 0) begin
        send_beat(tks_pkg::CH_QUOTE, 1'b0);
      end
    end else if (pick < 68) begin
      send_beat(pick_char(OPS), 1'b0);
      if ($urandom_range(2) == 0) begin
        send_beat(tks_pkg::CH_EQ, 1'b0);
      end
    end else if (pick < 73) begin
      send_text("//");
      repeat ($urandom_range(5)) begin
        do c = 8'($urandom_range(255)); while (c == tks_pkg::CH_LF);
        send_beat(c, 1'b0);
      end
      send_beat(tks_pkg::CH_LF, 1'b0);
    end else if (pick < 80) begin
      send_beat(8'($urandom_range(255)), 1'b0);
    end else if (pick < 83) begin
      // NUL ends the stream early; the tail is discarded up to the end mark.
      send_beat(tks_pkg::CH_NUL, 1'b0);
      repeat ($urandom_range(3)) send_beat(8'($urandom_range(255)), 1'b0);
      send_end();
    end else if (pick < 87) begin
      send_end();
    end
    if ($urandom_range(9) < 7) begin
      send_beat(blank_byte(), 1'b0);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Empty stream, keyword, six-letter word whose first five spell a keyword,
  // and a decimal cut short by a second dot.
  task automatic test_words_and_numbers();
    send_end();
    send_text("if whilex 7.5.");
    send_end();
  endtask

  // NUL inside a string is content; '_' and a high byte are errors; an open
  // '<' is flushed as a single operator by the end mark.
  task automatic test_string_and_errors();
    send_beat(tks_pkg::CH_QUOTE, 1'b0);
    send_beat(tks_pkg::CH_LOWER_A, 1'b0);
    send_beat(tks_pkg::CH_NUL, 1'b0);
    send_beat(tks_pkg::CH_QUOTE, 1'b0);
    send_beat(tks_pkg::CH_UNDER, 1'b0);
    send_beat(8'hff, 1'b0);
    send_beat(tks_pkg::CH_LT, 1'b0);
    send_end();
  endtask

  // NUL inside a comment ends nothing; NUL after a number flushes it, then
  // the tail and the end mark give no tokens.
  task automatic test_nul_handling();
    send_text("//");
    send_beat(tks_pkg::CH_NUL, 1'b0);
    send_beat(tks_pkg::CH_LF, 1'b0);
    send_beat(tks_pkg::CH_NINE, 1'b0);
    send_beat(tks_pkg::CH_NUL, 1'b0);
    send_beat(tks_pkg::CH_LOWER_Z, 1'b0);
    send_end();
  endtask

  // Long word that opens with a keyword: an identifier, never the keyword.
  task automatic test_long_word();
    gaps_on       = 1'b0;
    out_stalls_on = 1'b0;
    send_text("while");
    repeat (LONG_TAIL) send_beat(pick_char(WORD_TAIL), 1'b0);
    send_beat(tks_pkg::CH_SPACE, 1'b0);
    send_end();
    wait_for_drain();
  endtask

  // Hold the output off while operators keep coming, so the result queue
  // fills and in_if.ready drops; then pause until everything has drained.
  task automatic test_backpressure();
    gaps_on       = 1'b0;
    out_stalls_on = 1'b0;
    hold_request  = 300;
    repeat (80) send_beat(pick_char(OPS), 1'b0);
    send_end();
    wait_for_drain();
  endtask

  // Random text in phases of varied pacing, with the occasional full drain.
  task automatic test_random_text();
    int first_beat;
    int next_phase;
    first_beat = beats_sent;
    next_phase = beats_sent;
    while (beats_sent - first_beat < RANDOM_BEATS) begin
      if (beats_sent >= next_phase) begin
        if ($urandom_range(3) == 0) begin
          wait_for_drain();
        end
        gaps_on       = ($urandom_range(2) != 0);
        out_stalls_on = ($urandom_range(2) != 0);
        next_phase    = beats_sent + $urandom_range(60, 150);
      end
      send_random_piece();
    end
    send_end();
  endtask

  initial begin
    in_if.valid     <= 1'b0;
    in_if.text_byte <= 8'h00;
    in_if.end_mark  <= 1'b0;
    rst_ni          <= 1'b0;
    clear_scan();
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_words_and_numbers();
    test_string_and_errors();
    test_nul_handling();
    test_long_word();
    test_backpressure();
    test_random_text();

    // Every token accounted for, plus a settle window for strays.
    wait_for_drain();
    if (bad_tokens == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
